// ===== hdl/ipow_pkg.sv =====
package ipow_pkg;

	localparam int WORD_W = 64;

	typedef logic signed [WORD_W-1:0] word_t;

endpackage

// ===== hdl/ipow_in_if.sv =====
interface ipow_in_if;
	import ipow_pkg::*;

	logic  valid;
	logic  ready;
	word_t base;
	word_t exponent;

	modport source (output valid, output base, output exponent, input ready);
	modport sink (input valid, input base, input exponent, output ready);

endinterface

// ===== hdl/ipow_out_if.sv =====
interface ipow_out_if;
	import ipow_pkg::*;

	logic  valid;
	logic  ready;
	word_t power_result;

	modport source (output valid, output power_result, input ready);
	modport sink (input valid, input power_result, output ready);

endinterface

// ===== hdl/ipow_mul.sv =====
module ipow_mul #(
	parameter int W = 32
) (
	input  logic           clk,
	input  logic [W-1:0]   a,
	input  logic [W-1:0]   b,
	output logic [2*W-1:0] p_q
);

	always_ff @(posedge clk) begin
		p_q <= {{W{1'b0}}, a} * {{W{1'b0}}, b};
	end

endmodule

// ===== hdl/integer_power_by_squaring_top.sv =====
// A nonzero exponent is scanned past the leading zeros of its magnitude; then, for each bit
// below the leading one, the accumulator is squared and, if the bit is set, multiplied by the
// base. A zero exponent, or a negative one with a base other than 1 or -1, skips both. Each
// product runs in phases P0 to P3 on one shared half-width multiplier. One request at a time;
// the next request is taken while the previous result still waits at the output register.
// Reset: arst_n clears the sequencer and the output valid at once.
module integer_power_by_squaring_top #(
	parameter int DATA_WIDTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	ipow_in_if.sink    args,
	ipow_out_if.source power
);
	import ipow_pkg::*;

	localparam int HW    = (DATA_WIDTH + 1) / 2;
	localparam int LW    = DATA_WIDTH - HW;
	localparam int CNT_W = $clog2(DATA_WIDTH + 1);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_MUL, S_DONE} state_t;
	typedef enum logic [1:0] {P0, P1, P2, P3} phase_t;
	typedef enum logic {OP_SQR, OP_BASE} op_t;

	state_t                        state_q;
	phase_t                        ph_q;
	op_t                           op_q;
	logic        [CNT_W-1:0]       cnt_q;
	logic        [DATA_WIDTH-1:0]  mag_q;
	logic        [DATA_WIDTH-1:0]  b_q;
	logic        [DATA_WIDTH-1:0]  acc_q;
	logic        [DATA_WIDTH-1:0]  sum_q;
	logic        [LW-1:0]          cross_q;
	logic signed [DATA_WIDTH-1:0]  out_q;
	logic                          out_valid_q;

	logic [DATA_WIDTH-1:0] b_in;
	logic [DATA_WIDTH-1:0] e_in;
	logic [DATA_WIDTH-1:0] y;
	logic [HW-1:0]         xl, xh, yl, yh;
	logic [HW-1:0]         mul_a, mul_b;
	logic [2*HW-1:0]       prod_q;
	logic [DATA_WIDTH-1:0] prod_word;
	logic                  out_load;

	assign b_in = args.base[DATA_WIDTH-1:0];
	assign e_in = args.exponent[DATA_WIDTH-1:0];

	assign y  = (op_q == OP_SQR) ? acc_q : b_q;
	assign xl = acc_q[HW-1:0];
	assign xh = HW'(acc_q[DATA_WIDTH-1:HW]);
	assign yl = y[HW-1:0];
	assign yh = HW'(y[DATA_WIDTH-1:HW]);

	always_comb begin
		case (ph_q)
			P1: begin
				mul_a = xh;
				mul_b = yl;
			end
			P2: begin
				mul_a = xl;
				mul_b = yh;
			end
			default: begin
				mul_a = xl;
				mul_b = yl;
			end
		endcase
	end

	ipow_mul #(.W(HW)) u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod_q)
	);

	assign prod_word = sum_q + {LW'(cross_q + prod_q[LW-1:0]), {HW{1'b0}}};

	assign out_load = (state_q == S_DONE) && (!out_valid_q || power.ready);

	assign args.ready         = (state_q == S_IDLE);
	assign power.valid        = out_valid_q;
	assign power.power_result = WORD_W'(out_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ph_q        <= P0;
			op_q        <= OP_SQR;
			cnt_q       <= '0;
			mag_q       <= '0;
			b_q         <= '0;
			acc_q       <= '0;
			sum_q       <= '0;
			cross_q     <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && power.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (args.valid) begin
						b_q   <= b_in;
						cnt_q <= CNT_W'(DATA_WIDTH);
						if (e_in == '0) begin
							acc_q   <= DATA_WIDTH'(1);
							state_q <= S_DONE;
						end else if (e_in[DATA_WIDTH-1] && (b_in != DATA_WIDTH'(1)) && !(&b_in)) begin
							acc_q   <= '0;
							state_q <= S_DONE;
						end else begin
							mag_q   <= e_in[DATA_WIDTH-1] ? (~e_in + 1'b1) : e_in;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					mag_q <= {mag_q[DATA_WIDTH-2:0], 1'b0};
					cnt_q <= cnt_q - 1'b1;
					if (mag_q[DATA_WIDTH-1]) begin
						acc_q <= b_q;
						op_q  <= OP_SQR;
						ph_q  <= P0;
						if (cnt_q == CNT_W'(1)) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					case (ph_q)
						P0: ph_q <= P1;
						P1: begin
							sum_q <= prod_q[DATA_WIDTH-1:0];
							ph_q  <= P2;
						end
						P2: begin
							cross_q <= prod_q[LW-1:0];
							ph_q    <= P3;
						end
						default: begin
							acc_q <= prod_word;
							ph_q  <= P0;
							if (op_q == OP_SQR && mag_q[DATA_WIDTH-1]) begin
								op_q <= OP_BASE;
							end else begin
								op_q  <= OP_SQR;
								mag_q <= {mag_q[DATA_WIDTH-2:0], 1'b0};
								cnt_q <= cnt_q - 1'b1;
								if (cnt_q == CNT_W'(1)) begin
									state_q <= S_DONE;
								end
							end
						end
					endcase
				end
				S_DONE: begin
					if (out_load) begin
						out_q   <= acc_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		args.valid && args.ready |=> !args.ready)
		else $error("request taken while a request is in progress");

	a_scan_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> mag_q != '0)
		else $error("leading-zero scan on an empty magnitude");

	a_base_on_set_bit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MUL && op_q == OP_BASE |-> mag_q[DATA_WIDTH-1])
		else $error("base multiply on a clear exponent bit");

	a_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN || state_q == S_MUL |-> cnt_q != '0)
		else $error("bit counter underflow");

endmodule
